@@ src/tok_pkg.sv @@
// Shared types, token kind codes, character codes and classifiers for the tokenizer.
package tok_pkg;

  localparam int MAX_ITEMS = 3;

  typedef enum logic [3:0] {
    M_IDLE,
    M_INT,
    M_ID,
    M_STR,
    M_CHR,
    M_CHR_TAIL,
    M_OPEQ,
    M_HASH1,
    M_LINE,
    M_BLOCK,
    M_BLOCK_TAIL
  } mode_t;

  localparam logic [4:0] K_INT    = 5'd0;
  localparam logic [4:0] K_ID     = 5'd1;
  localparam logic [4:0] K_STR    = 5'd2;
  localparam logic [4:0] K_CHR    = 5'd3;
  localparam logic [4:0] K_PLUS   = 5'd4;
  localparam logic [4:0] K_MINUS  = 5'd5;
  localparam logic [4:0] K_STAR   = 5'd6;
  localparam logic [4:0] K_SLASH  = 5'd7;
  localparam logic [4:0] K_EQEQ   = 5'd8;
  localparam logic [4:0] K_GE     = 5'd9;
  localparam logic [4:0] K_LE     = 5'd10;
  localparam logic [4:0] K_ASSIGN = 5'd11;
  localparam logic [4:0] K_GT     = 5'd12;
  localparam logic [4:0] K_LT     = 5'd13;
  localparam logic [4:0] K_SEMI   = 5'd14;
  localparam logic [4:0] K_LPAREN = 5'd15;
  localparam logic [4:0] K_RPAREN = 5'd16;
  localparam logic [4:0] K_LBRACE = 5'd17;
  localparam logic [4:0] K_RBRACE = 5'd18;
  localparam logic [4:0] K_LBRACK = 5'd19;
  localparam logic [4:0] K_RBRACK = 5'd20;
  localparam logic [4:0] K_COMMA  = 5'd21;
  localparam logic [4:0] K_EOF    = 5'd22;
  localparam logic [4:0] K_BAD    = 5'd23;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text_byte;
    logic       has_text;
    logic       token_first;
    logic       token_last;
    logic       unterminated;
  } tok_item_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h2b:   k = K_PLUS;
      8'h2d:   k = K_MINUS;
      8'h2a:   k = K_STAR;
      8'h2f:   k = K_SLASH;
      8'h3b:   k = K_SEMI;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7b:   k = K_LBRACE;
      8'h7d:   k = K_RBRACE;
      8'h5b:   k = K_LBRACK;
      8'h5d:   k = K_RBRACK;
      8'h2c:   k = K_COMMA;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

  // Kind of a held relational or assignment character, alone or followed by '='.
  function automatic logic [4:0] op_kind(logic [7:0] c, logic two);
    logic [4:0] k;
    if (c == CH_GT) begin
      k = two ? K_GE : K_GT;
    end else if (c == CH_LT) begin
      k = two ? K_LE : K_LT;
    end else begin
      k = two ? K_EQEQ : K_ASSIGN;
    end
    return k;
  endfunction

  function automatic tok_item_t mk_item(logic [4:0] k, logic [7:0] ch, logic has,
                                        logic first, logic last, logic unterm);
    tok_item_t it;
    it.kind         = k;
    it.text_byte    = has ? ch : 8'h00;
    it.has_text     = has;
    it.token_first  = first;
    it.token_last   = last;
    it.unterminated = unterm;
    return it;
  endfunction

endpackage

@@ src/tok_if.sv @@
// Valid/ready channel interfaces for source bytes and token items.
interface tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink (input valid, input byte_value, input final_byte, output ready);
endinterface

interface tok_out_if #(parameter int LINE_BITS = 20);
  logic                 valid;
  logic                 ready;
  logic [4:0]           kind;
  logic [7:0]           text_byte;
  logic                 has_text;
  logic                 token_first;
  logic                 token_last;
  logic [LINE_BITS-1:0] line_number;
  logic                 unterminated;
  logic                 run_last;

  modport source (output valid, output kind, output text_byte, output has_text,
                  output token_first, output token_last, output line_number,
                  output unterminated, output run_last, input ready);
  modport sink (input valid, input kind, input text_byte, input has_text,
                input token_first, input token_last, input line_number,
                input unterminated, input run_last, output ready);
endinterface

@@ src/tok_front.sv @@
// Scanner front end: classifies each byte and produces the bundle of items it causes.
module tok_front #(
  parameter int LINE_BITS = 20
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_fire,
  input  logic [7:0]                                byte_value,
  input  logic                                      final_byte,
  output logic                                      push,
  output logic [1:0]                                bundle_cnt,
  output tok_pkg::tok_item_t [tok_pkg::MAX_ITEMS-1:0] items,
  output logic [tok_pkg::MAX_ITEMS-1:0][LINE_BITS-1:0] lines
);

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_SAT = {LINE_BITS{1'b1}};

  tok_pkg::mode_t       mode_r, mode_nxt;
  logic [7:0]           hb_r, hb_nxt;
  logic                 hv_r, hv_nxt;
  logic [LINE_BITS-1:0] lc_r, lc_nxt;
  logic [LINE_BITS-1:0] tl_r, tl_nxt;
  logic                 topen_r, topen_nxt;
  logic                 tdone_r, tdone_nxt;

  always_comb begin : scan
    logic [7:0] c;
    logic       do_start;
    logic       do_finish;
    logic       open_f;
    logic       cont;
    logic [4:0] k;

    c          = byte_value;
    do_start   = 1'b0;
    do_finish  = 1'b0;
    open_f     = 1'b0;
    cont       = 1'b0;
    k          = tok_pkg::K_INT;
    mode_nxt   = mode_r;
    hb_nxt     = hb_r;
    hv_nxt     = hv_r;
    lc_nxt     = lc_r;
    tl_nxt     = tl_r;
    topen_nxt  = topen_r;
    tdone_nxt  = tdone_r;
    bundle_cnt = 2'd0;
    items      = '0;
    lines      = '0;

    if (tdone_r) begin
      // After an end-of-text byte everything up to the final byte is dropped.
      if (final_byte) begin
        tdone_nxt = 1'b0;
      end
    end else if (c == tok_pkg::CH_NUL) begin
      do_finish = 1'b1;
      tdone_nxt = ~final_byte;
    end else begin
      unique case (mode_r)
        tok_pkg::M_INT, tok_pkg::M_ID: begin
          k    = (mode_r == tok_pkg::M_INT) ? tok_pkg::K_INT : tok_pkg::K_ID;
          cont = (mode_r == tok_pkg::M_INT) ? tok_pkg::is_digit(c) : tok_pkg::is_alnum(c);
          items[bundle_cnt] = tok_pkg::mk_item(k, hb_r, 1'b1, ~topen_r, ~cont, 1'b0);
          lines[bundle_cnt] = tl_r;
          bundle_cnt        = bundle_cnt + 2'd1;
          if (cont) begin
            topen_nxt = 1'b1;
            hb_nxt    = c;
          end else begin
            do_start = 1'b1;
          end
        end
        tok_pkg::M_STR: begin
          if (c == tok_pkg::CH_DQUOTE) begin
            if (hv_r) begin
              items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_STR, hb_r, 1'b1, ~topen_r,
                                                   1'b1, 1'b0);
            end else begin
              items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_STR, 8'h00, 1'b0, 1'b1,
                                                   1'b1, 1'b0);
            end
            lines[bundle_cnt] = tl_r;
            bundle_cnt        = bundle_cnt + 2'd1;
            mode_nxt          = tok_pkg::M_IDLE;
            hv_nxt            = 1'b0;
            topen_nxt         = 1'b0;
          end else begin
            if (hv_r) begin
              items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_STR, hb_r, 1'b1, ~topen_r,
                                                   1'b0, 1'b0);
              lines[bundle_cnt] = tl_r;
              bundle_cnt        = bundle_cnt + 2'd1;
              topen_nxt         = 1'b1;
            end
            hb_nxt = c;
            hv_nxt = 1'b1;
          end
        end
        tok_pkg::M_CHR: begin
          items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_CHR, c, 1'b1, 1'b1, 1'b1, 1'b0);
          lines[bundle_cnt] = tl_r;
          bundle_cnt        = bundle_cnt + 2'd1;
          mode_nxt          = tok_pkg::M_CHR_TAIL;
        end
        tok_pkg::M_CHR_TAIL, tok_pkg::M_BLOCK_TAIL: begin
          mode_nxt = tok_pkg::M_IDLE;
        end
        tok_pkg::M_OPEQ: begin
          if (c == tok_pkg::CH_EQ) begin
            k = tok_pkg::op_kind(hb_r, 1'b1);
            items[bundle_cnt] = tok_pkg::mk_item(k, hb_r, 1'b1, 1'b1, 1'b0, 1'b0);
            lines[bundle_cnt] = tl_r;
            bundle_cnt        = bundle_cnt + 2'd1;
            items[bundle_cnt] = tok_pkg::mk_item(k, c, 1'b1, 1'b0, 1'b1, 1'b0);
            lines[bundle_cnt] = tl_r;
            bundle_cnt        = bundle_cnt + 2'd1;
            mode_nxt          = tok_pkg::M_IDLE;
            hv_nxt            = 1'b0;
          end else begin
            items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::op_kind(hb_r, 1'b0), hb_r, 1'b1,
                                                 1'b1, 1'b1, 1'b0);
            lines[bundle_cnt] = tl_r;
            bundle_cnt        = bundle_cnt + 2'd1;
            do_start          = 1'b1;
          end
        end
        tok_pkg::M_HASH1: begin
          if (c == tok_pkg::CH_HASH) begin
            mode_nxt = tok_pkg::M_BLOCK;
          end else if (c == tok_pkg::CH_LF) begin
            if (lc_nxt != LINE_SAT) lc_nxt = lc_nxt + LINE_ONE;
            mode_nxt = tok_pkg::M_IDLE;
          end else begin
            mode_nxt = tok_pkg::M_LINE;
          end
        end
        tok_pkg::M_LINE: begin
          if (c == tok_pkg::CH_LF) begin
            if (lc_nxt != LINE_SAT) lc_nxt = lc_nxt + LINE_ONE;
            mode_nxt = tok_pkg::M_IDLE;
          end
        end
        tok_pkg::M_BLOCK: begin
          if (c == tok_pkg::CH_HASH) begin
            mode_nxt = tok_pkg::M_BLOCK_TAIL;
          end else if (c == tok_pkg::CH_LF) begin
            if (lc_nxt != LINE_SAT) lc_nxt = lc_nxt + LINE_ONE;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      // A byte ending a token or between tokens opens a new token, a comment, or nothing.
      if (do_start) begin
        mode_nxt  = tok_pkg::M_IDLE;
        hv_nxt    = 1'b0;
        topen_nxt = 1'b0;
        if (c == tok_pkg::CH_SPACE) begin
          mode_nxt = tok_pkg::M_IDLE;
        end else if (c == tok_pkg::CH_LF) begin
          if (lc_nxt != LINE_SAT) lc_nxt = lc_nxt + LINE_ONE;
        end else if (c == tok_pkg::CH_HASH) begin
          mode_nxt = tok_pkg::M_HASH1;
        end else begin
          tl_nxt = lc_nxt;
          if (tok_pkg::is_alnum(c)) begin
            hb_nxt   = c;
            hv_nxt   = 1'b1;
            mode_nxt = tok_pkg::is_digit(c) ? tok_pkg::M_INT : tok_pkg::M_ID;
          end else if (c == tok_pkg::CH_DQUOTE) begin
            mode_nxt = tok_pkg::M_STR;
          end else if (c == tok_pkg::CH_QUOTE) begin
            mode_nxt = tok_pkg::M_CHR;
          end else if ((c == tok_pkg::CH_EQ) || (c == tok_pkg::CH_GT) ||
                       (c == tok_pkg::CH_LT)) begin
            hb_nxt   = c;
            hv_nxt   = 1'b1;
            mode_nxt = tok_pkg::M_OPEQ;
          end else begin
            items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::single_kind(c), c, 1'b1, 1'b1,
                                                 1'b1, 1'b0);
            lines[bundle_cnt] = tl_nxt;
            bundle_cnt        = bundle_cnt + 2'd1;
          end
        end
      end
      do_finish = final_byte;
    end

    // End of text: flush what is held, then the end-of-file item.
    if (do_finish) begin
      case (mode_nxt)
        tok_pkg::M_INT, tok_pkg::M_ID: begin
          k = (mode_nxt == tok_pkg::M_INT) ? tok_pkg::K_INT : tok_pkg::K_ID;
          items[bundle_cnt] = tok_pkg::mk_item(k, hb_nxt, 1'b1, ~topen_nxt, 1'b1, 1'b0);
          lines[bundle_cnt] = tl_nxt;
          bundle_cnt        = bundle_cnt + 2'd1;
        end
        tok_pkg::M_STR: begin
          if (hv_nxt) begin
            items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_STR, hb_nxt, 1'b1, ~topen_nxt,
                                                 1'b1, 1'b0);
          end else begin
            items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_STR, 8'h00, 1'b0, 1'b1, 1'b1,
                                                 1'b0);
          end
          lines[bundle_cnt] = tl_nxt;
          bundle_cnt        = bundle_cnt + 2'd1;
          open_f            = 1'b1;
        end
        tok_pkg::M_CHR: begin
          items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_CHR, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
          lines[bundle_cnt] = tl_nxt;
          bundle_cnt        = bundle_cnt + 2'd1;
          open_f            = 1'b1;
        end
        tok_pkg::M_CHR_TAIL, tok_pkg::M_BLOCK: begin
          open_f = 1'b1;
        end
        tok_pkg::M_OPEQ: begin
          items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::op_kind(hb_nxt, 1'b0), hb_nxt, 1'b1,
                                               1'b1, 1'b1, 1'b0);
          lines[bundle_cnt] = tl_nxt;
          bundle_cnt        = bundle_cnt + 2'd1;
        end
        default: begin
          open_f = 1'b0;
        end
      endcase
      items[bundle_cnt] = tok_pkg::mk_item(tok_pkg::K_EOF, 8'h00, 1'b0, 1'b1, 1'b1, open_f);
      lines[bundle_cnt] = lc_nxt;
      bundle_cnt        = bundle_cnt + 2'd1;
      mode_nxt          = tok_pkg::M_IDLE;
      hb_nxt            = 8'h00;
      hv_nxt            = 1'b0;
      lc_nxt            = LINE_ONE;
      tl_nxt            = LINE_ONE;
      topen_nxt         = 1'b0;
    end
  end

  assign push = in_fire && (bundle_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tok_pkg::M_IDLE;
      hb_r    <= 8'h00;
      hv_r    <= 1'b0;
      lc_r    <= LINE_ONE;
      tl_r    <= LINE_ONE;
      topen_r <= 1'b0;
      tdone_r <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      hb_r    <= hb_nxt;
      hv_r    <= hv_nxt;
      lc_r    <= lc_nxt;
      tl_r    <= tl_nxt;
      topen_r <= topen_nxt;
      tdone_r <= tdone_nxt;
    end
  end

endmodule

@@ src/tok_queue.sv @@
// Small register queue holding item bundles between the scanner and the output stage.
module tok_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/tok_back.sv @@
// Output stage: registered, sends bundle items one per cycle while the sink is ready.
module tok_back #(
  parameter int LINE_BITS = 20
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         head_valid,
  input  logic [1:0]                                   head_cnt,
  input  tok_pkg::tok_item_t [tok_pkg::MAX_ITEMS-1:0]  head_items,
  input  logic [tok_pkg::MAX_ITEMS-1:0][LINE_BITS-1:0] head_lines,
  output logic                                         pop,
  tok_out_if.source                                    out_ch
);

  logic                 out_valid_r;
  logic [1:0]           idx_r;
  tok_pkg::tok_item_t   item_r;
  logic [LINE_BITS-1:0] line_r;
  logic                 run_last_r;
  logic                 load;
  logic                 last_sel;

  assign load     = head_valid && (!out_valid_r || out_ch.ready);
  assign last_sel = (idx_r == (head_cnt - 2'd1));
  assign pop      = load && last_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last_sel ? 2'd0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r     <= head_items[idx_r];
      line_r     <= head_lines[idx_r];
      run_last_r <= last_sel;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = item_r.kind;
  assign out_ch.text_byte    = item_r.text_byte;
  assign out_ch.has_text     = item_r.has_text;
  assign out_ch.token_first  = item_r.token_first;
  assign out_ch.token_last   = item_r.token_last;
  assign out_ch.line_number  = line_r;
  assign out_ch.unterminated = item_r.unterminated;
  assign out_ch.run_last     = run_last_r;

endmodule

@@ src/source_text_tokenizer_top.sv @@
// Streaming tokenizer: scanner front end, bundle queue and item output stage.
// The first item caused by a byte passes through the queue and the output register.
// The scanner takes one byte per cycle while the queue has room; the output register
// sends one item per cycle while the receiver is ready, so a byte causing n items
// (n up to 3) holds the output until all are sent and the queue absorbs short bursts.
// Reset (synchronous, rst_n low): scanner idle at line 1, queue and output empty.
module source_text_tokenizer_top #(
  parameter int LINE_BITS   = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  tok_in_if.sink    in_ch,
  tok_out_if.source out_ch
);

  localparam int ITEM_W = $bits(tok_pkg::tok_item_t);
  localparam int QW     = 2 + tok_pkg::MAX_ITEMS * (ITEM_W + LINE_BITS);

  logic                                         in_fire;
  logic                                         f_push;
  logic [1:0]                                   f_cnt;
  tok_pkg::tok_item_t [tok_pkg::MAX_ITEMS-1:0]  f_items;
  logic [tok_pkg::MAX_ITEMS-1:0][LINE_BITS-1:0] f_lines;
  logic                                         q_full;
  logic                                         q_valid;
  logic                                         q_pop;
  logic [QW-1:0]                                q_wdata;
  logic [QW-1:0]                                q_rdata;
  logic [1:0]                                   h_cnt;
  tok_pkg::tok_item_t [tok_pkg::MAX_ITEMS-1:0]  h_items;
  logic [tok_pkg::MAX_ITEMS-1:0][LINE_BITS-1:0] h_lines;

  assign in_ch.ready = ~q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  tok_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .byte_value (in_ch.byte_value),
    .final_byte (in_ch.final_byte),
    .push       (f_push),
    .bundle_cnt (f_cnt),
    .items      (f_items),
    .lines      (f_lines)
  );

  assign q_wdata = {f_cnt, f_items, f_lines};

  tok_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .wdata      (q_wdata),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_rdata)
  );

  assign {h_cnt, h_items, h_lines} = q_rdata;

  tok_back #(.LINE_BITS(LINE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cnt   (h_cnt),
    .head_items (h_items),
    .head_lines (h_lines),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  // A queued bundle always holds at least one item.
  a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (h_cnt != 2'd0))
    else $error("empty bundle at queue head");

  // The end-of-file item is a whole token with no text.
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == tok_pkg::K_EOF)) |->
      (out_ch.token_first && out_ch.token_last && !out_ch.has_text))
    else $error("malformed end-of-file item");

  // Only the end-of-file item reports an open construct.
  a_unterm_eof_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.unterminated) |-> (out_ch.kind == tok_pkg::K_EOF))
    else $error("unterminated flag on a non end-of-file item");

  // Line numbers start at one and never wrap to zero.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.line_number != '0))
    else $error("line number zero");

endmodule
